// File: design/tbcm_pkg.sv
// ----------------------------------------------------------------------------
// tbcm_pkg
// Shared constants and types of the three-band compressor.
// ----------------------------------------------------------------------------
package tbcm_pkg;
    localparam int NUM_CHANNELS = 2;
    localparam int NUM_BANDS    = 3;
    localparam int SAMPLE_BITS  = 24;
    localparam int ENV_DEPTH    = NUM_CHANNELS * NUM_BANDS;
    localparam int ENV_AW       = $clog2(ENV_DEPTH);
    localparam int CFG_AW       = 3;
    localparam int CFG_DW       = 24;

    localparam logic [CFG_AW-1:0] REG_LOW_THR  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_MID_THR  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_HIGH_THR = 3'd2;
    localparam logic [CFG_AW-1:0] REG_ATTACK   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_RELEASE  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_INV_RAT  = 3'd5;
    localparam logic [CFG_AW-1:0] REG_MIX      = 3'd6;
    localparam logic [CFG_AW-1:0] REG_OUT_GAIN = 3'd7;

    typedef struct packed {
        logic               channel;
        logic signed [23:0] low_sample;
        logic signed [23:0] mid_sample;
        logic signed [23:0] high_sample;
        logic signed [23:0] dry_sample;
    } t_in;

    typedef struct packed {
        logic               out_channel;
        logic signed [23:0] out_sample;
    } t_out;

    typedef struct packed {
        logic signed [14:0] thr0;
        logic signed [14:0] thr1;
        logic signed [14:0] thr2;
        logic [23:0]        attack;
        logic [23:0]        rel;
        logic [16:0]        inv_ratio;
        logic [16:0]        mix;
        logic [18:0]        out_gain;
    } t_cfg;
endpackage

// File: design/tbcm_stream_if.sv
// ----------------------------------------------------------------------------
// tbcm_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface tbcm_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/tbcm_mul.sv
// ----------------------------------------------------------------------------
// tbcm_mul
// Radix-4 serial unsigned multiplier, 48 x 32 bits, two multiplier bits a cycle.
// ----------------------------------------------------------------------------
module tbcm_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [79:0] o_p
);
    logic [79:0] r_acc, n_acc;
    logic [79:0] r_a, n_a;
    logic [31:0] r_b, n_b;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [79:0] w_pp;

    always_comb begin
        w_pp = (r_b[0] ? r_a : 80'd0) + (r_b[1] ? {r_a[78:0], 1'b0} : 80'd0);
        n_acc = r_acc; n_a = r_a; n_b = r_b; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        if (i_start) begin
            n_acc = '0; n_a = {32'd0, i_a}; n_b = i_b; n_cnt = '0; n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = r_acc + w_pp;
            n_a = {r_a[77:0], 2'b00};
            n_b = {2'b00, r_b[31:2]};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd15) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc; r_a <= n_a; r_b <= n_b; r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

// File: design/tbcm_cfg.sv
// ----------------------------------------------------------------------------
// tbcm_cfg
// Configuration register file with clamping of ratio and mix.
// ----------------------------------------------------------------------------
module tbcm_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tbcm_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [tbcm_pkg::CFG_DW-1:0] i_cfg_data,
    output tbcm_pkg::t_cfg              o_cfg
);
    import tbcm_pkg::*;
    t_cfg r_cfg;
    logic [16:0] w_v17;
    assign w_v17 = i_cfg_data[16:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr0 <= -15'sd6144;
            r_cfg.thr1 <= -15'sd4608;
            r_cfg.thr2 <= -15'sd3072;
            r_cfg.attack <= 24'd16742315;
            r_cfg.rel <= 24'd16774884;
            r_cfg.inv_ratio <= 17'd21845;
            r_cfg.mix <= 17'd65536;
            r_cfg.out_gain <= 19'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LOW_THR:  r_cfg.thr0 <= i_cfg_data[14:0];
                REG_MID_THR:  r_cfg.thr1 <= i_cfg_data[14:0];
                REG_HIGH_THR: r_cfg.thr2 <= i_cfg_data[14:0];
                REG_ATTACK:   r_cfg.attack <= i_cfg_data;
                REG_RELEASE:  r_cfg.rel <= i_cfg_data;
                REG_INV_RAT:  r_cfg.inv_ratio <= w_v17[16] ? 17'd65536 : w_v17;
                REG_MIX:      r_cfg.mix <= w_v17[16] ? 17'd65536 : w_v17;
                REG_OUT_GAIN: r_cfg.out_gain <= i_cfg_data[18:0];
                default: ;
            endcase
        end
    end
    assign o_cfg = r_cfg;
endmodule

// File: design/three_band_compressor_mix_top.sv
// ----------------------------------------------------------------------------
// three_band_compressor_mix_top
// Three-band compressor with dry/wet mix and output trim.
// Every product runs through one radix-4 serial multiplier in the sequencer,
// sixteen of them for the log2 of each band whose envelope is not zero.
// Throughput: one item at a time; the next is taken once the sequencer is idle,
// a result still held at the output stalls the sequencer in its last step.
// Reset: registers take their default values, envelopes clear to zero.
// ----------------------------------------------------------------------------
module three_band_compressor_mix_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tbcm_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [tbcm_pkg::CFG_DW-1:0] i_cfg_data,
    tbcm_stream_if.sink                 in_if,
    tbcm_stream_if.source               out_if
);
    import tbcm_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0,  S_ENV1 = 5'd1,  S_ENV2 = 5'd2,
                           S_ENV3 = 5'd3,  S_NORM = 5'd4,  S_LOGM = 5'd5,
                           S_LOGW = 5'd6,  S_DB   = 5'd7,  S_RAT  = 5'd8,
                           S_R2   = 5'd9,  S_EX1  = 5'd10, S_EX2  = 5'd11,
                           S_EX3  = 5'd12, S_BAND = 5'd13, S_NEXT = 5'd14,
                           S_MX1  = 5'd15, S_MX2  = 5'd16, S_OG   = 5'd17,
                           S_OUT  = 5'd18, S_ENVW = 5'd19;

    t_cfg w_cfg;
    tbcm_cfg u_cfg (.i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_cfg(w_cfg));

    logic        r_mul_start, m_done;
    logic [47:0] r_mul_a;
    logic [31:0] r_mul_b;
    logic [79:0] m_p;
    tbcm_mul u_mul (.i_clk, .i_rst_n, .i_start(r_mul_start), .i_a(r_mul_a), .i_b(r_mul_b),
                    .o_done(m_done), .o_p(m_p));

    logic [31:0] r_env [ENV_DEPTH];
    logic [4:0]  r_st;
    logic        r_wait;
    t_in         r_in;
    logic [1:0]  r_band;
    logic [ENV_AW-1:0] r_idx;
    logic [23:0] r_abs;
    logic        r_neg;
    logic [31:0] r_lvl, r_e;
    logic [23:0] r_c;
    logic [56:0] r_sum;
    logic [4:0]  r_p;
    logic [31:0] r_m;
    logic [15:0] r_frac;
    logic [4:0]  r_it;
    logic [47:0] r_t;
    logic [16:0] r_x;
    logic [5:0]  r_k;
    logic [16:0] r_gain;
    logic signed [27:0] r_wet;
    logic signed [43:0] r_mx;
    t_out        r_res;
    t_out        r_out;
    logic        r_ovalid;

    logic signed [23:0] w_s;
    logic signed [14:0] w_thr;
    always_comb begin
        case (r_band)
            2'd0: begin w_s = r_in.low_sample; w_thr = w_cfg.thr0; end
            2'd1: begin w_s = r_in.mid_sample; w_thr = w_cfg.thr1; end
            default: begin w_s = r_in.high_sample; w_thr = w_cfg.thr2; end
        endcase
    end

    logic [4:0] w_top;
    always_comb begin
        w_top = 5'd0;
        for (int i = 0; i < 32; i++)
            if (r_e[i]) w_top = 5'(i);
    end

    logic signed [25:0] w_over;
    assign w_over = -($signed({{11{w_thr[14]}}, w_thr}) * 26'sd256) - $signed({1'b0, r_t[24:0]});
    logic [40:0] w_rb;
    assign w_rb = m_p[40:0] + 41'd32768;

    assign in_if.ready  = (r_st == S_IDLE);
    assign out_if.valid = r_ovalid;
    assign out_if.data  = r_out;

    always_ff @(posedge i_clk) begin
        r_mul_start <= 1'b0;
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ovalid <= 1'b0; r_wait <= 1'b0;
            for (int i = 0; i < ENV_DEPTH; i++) r_env[i] <= '0;
        end else begin
            if (out_if.valid && out_if.ready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (in_if.valid && in_if.ready) begin
                    r_in <= in_if.data; r_band <= 2'd0; r_wet <= '0;
                    r_idx <= in_if.data.channel ? ENV_AW'(NUM_BANDS) : '0;
                    r_st <= S_ENV1;
                end
                S_ENV1: begin
                    r_neg <= w_s[23];
                    r_abs <= w_s[23] ? 24'(-w_s) : w_s;
                    r_lvl <= {(w_s[23] ? 24'(-w_s) : w_s), 8'd0};
                    r_e <= r_env[r_idx];
                    r_st <= S_ENV2; r_wait <= 1'b0;
                end
                S_ENV2: if (!r_wait) begin
                    r_c <= (r_lvl > r_e) ? w_cfg.attack : w_cfg.rel;
                    r_mul_a <= {16'd0, r_e};
                    r_mul_b <= {8'd0, (r_lvl > r_e) ? w_cfg.attack : w_cfg.rel};
                    r_mul_start <= 1'b1; r_wait <= 1'b1;
                end else if (m_done) begin
                    r_sum <= m_p[56:0] + 57'h800000;
                    r_mul_a <= {16'd0, r_lvl};
                    r_mul_b <= 32'(25'h1000000 - {1'b0, r_c});
                    r_mul_start <= 1'b1; r_wait <= 1'b0; r_st <= S_ENV3;
                end
                S_ENV3: if (m_done) begin
                    logic [56:0] t;
                    t = r_sum + m_p[56:0];
                    r_e <= (t[56:24] > 33'hFFFFFFFF) ? 32'hFFFFFFFF : t[55:24];
                    r_st <= S_ENVW;
                end
                S_ENVW: begin
                    r_env[r_idx] <= r_e;
                    r_gain <= 17'd65536;
                    r_st <= (r_e == 32'd0) ? S_BAND : S_NORM;
                end
                S_NORM: begin
                    r_p <= w_top;
                    r_m <= (w_top == 5'd31) ? {1'b0, r_e[31:1]} : (r_e << (5'd30 - w_top));
                    r_frac <= '0; r_it <= 5'd0; r_wait <= 1'b0; r_st <= S_LOGM;
                end
                S_LOGM: if (!r_wait) begin
                    r_mul_a <= {16'd0, r_m}; r_mul_b <= r_m; r_mul_start <= 1'b1;
                    r_wait <= 1'b1;
                end else if (m_done) begin
                    r_wait <= 1'b0;
                    if (m_p[61]) begin
                        r_m <= m_p[62:31]; r_frac <= {r_frac[14:0], 1'b1};
                    end else begin
                        r_m <= m_p[61:30]; r_frac <= {r_frac[14:0], 1'b0};
                    end
                    r_it <= r_it + 5'd1;
                    if (r_it == 5'd15) r_st <= S_LOGW;
                end
                S_LOGW: begin
                    logic [21:0] d;
                    d = {1'b0, 5'd31 - r_p, 16'd0} - {6'd0, r_frac};
                    r_mul_a <= {26'd0, d}; r_mul_b <= 32'd394566; r_mul_start <= 1'b1;
                    r_st <= S_DB;
                end
                S_DB: if (m_done) begin
                    r_t <= {8'd0, m_p[55:16]};
                    r_st <= S_RAT;
                end
                S_RAT: begin
                    if (r_t[47:25] != 0 || w_over <= 0) r_st <= S_BAND;
                    else begin
                        r_mul_a <= {22'd0, w_over};
                        r_mul_b <= 32'(17'd65536 - w_cfg.inv_ratio);
                        r_mul_start <= 1'b1; r_st <= S_R2;
                    end
                    r_wait <= 1'b0;
                end
                S_R2: if (!r_wait) begin
                    if (m_done) begin
                        r_mul_a <= m_p[63:16]; r_mul_b <= 32'd10885; r_mul_start <= 1'b1;
                        r_wait <= 1'b1;
                    end
                end else if (m_done) begin
                    logic [25:0] r2;
                    r2 = m_p[41:16];
                    r_wait <= 1'b0;
                    if (r2[15:0] != 0) begin
                        r_k <= (r2[25:16] > 10'd31) ? 6'd32 : 6'(r2[25:16]) + 6'd1;
                        r_x <= 17'd65536 - {1'b0, r2[15:0]};
                    end else begin
                        r_k <= (r2[25:16] > 10'd31) ? 6'd32 : 6'(r2[25:16]);
                        r_x <= '0;
                    end
                    r_mul_a <= 48'd5216;
                    r_mul_b <= 32'(r2[15:0] != 0 ? 17'd65536 - {1'b0, r2[15:0]} : 17'd0);
                    r_mul_start <= 1'b1; r_st <= S_EX1;
                end
                S_EX1: if (m_done) begin
                    r_mul_a <= 48'd14726 + {16'd0, m_p[47:16]}; r_mul_b <= {15'd0, r_x};
                    r_mul_start <= 1'b1; r_st <= S_EX2;
                end
                S_EX2: if (m_done) begin
                    r_mul_a <= 48'd45594 + {16'd0, m_p[47:16]}; r_mul_b <= {15'd0, r_x};
                    r_mul_start <= 1'b1; r_st <= S_EX3;
                end
                S_EX3: if (m_done) begin
                    logic [47:0] g;
                    g = (48'd65536 + {16'd0, m_p[47:16]}) >> r_k;
                    r_gain <= (r_k > 6'd31) ? 17'd0 : g[16:0];
                    r_st <= S_BAND; r_wait <= 1'b0;
                end
                S_BAND: if (!r_wait) begin
                    r_mul_a <= {24'd0, r_abs}; r_mul_b <= {15'd0, r_gain}; r_mul_start <= 1'b1;
                    r_wait <= 1'b1;
                end else if (m_done) begin
                    r_wait <= 1'b0;
                    r_wet <= r_neg ? r_wet - $signed({3'd0, w_rb[40:16]})
                                   : r_wet + $signed({3'd0, w_rb[40:16]});
                    r_st <= S_NEXT;
                end
                S_NEXT: begin
                    r_idx <= r_idx + ENV_AW'(1);
                    if (r_band == 2'd2) begin
                        r_band <= 2'd0; r_st <= S_MX1; r_wait <= 1'b0;
                    end else begin
                        r_band <= r_band + 2'd1; r_st <= S_ENV1;
                    end
                end
                S_MX1: if (!r_wait) begin
                    r_mul_a <= {20'd0, r_wet[27] ? 28'(-r_wet) : r_wet};
                    r_mul_b <= {15'd0, w_cfg.mix}; r_mul_start <= 1'b1; r_wait <= 1'b1;
                end else if (m_done) begin
                    r_mx <= r_wet[27] ? -$signed(m_p[43:0]) : $signed(m_p[43:0]);
                    r_mul_a <= {24'd0, r_in.dry_sample[23] ? 24'(-r_in.dry_sample)
                                                           : r_in.dry_sample};
                    r_mul_b <= 32'(17'd65536 - w_cfg.mix); r_mul_start <= 1'b1;
                    r_wait <= 1'b0; r_st <= S_MX2;
                end
                S_MX2: if (m_done) begin
                    logic signed [44:0] v;
                    logic [44:0] mg;
                    v = r_in.dry_sample[23] ? 45'(r_mx) - $signed({1'b0, m_p[43:0]})
                                            : 45'(r_mx) + $signed({1'b0, m_p[43:0]});
                    mg = (v[44] ? 45'(-v) : v) + 45'd32768;
                    r_neg <= v[44];
                    r_mul_a <= {20'd0, mg[43:16]}; r_mul_b <= {13'd0, w_cfg.out_gain};
                    r_mul_start <= 1'b1; r_st <= S_OG;
                end
                S_OG: if (m_done) begin
                    logic [63:0] q;
                    q = (m_p[63:0] + 64'd32768) >> 16;
                    r_res.out_channel <= r_in.channel;
                    if (!r_neg) r_res.out_sample <= (q > 64'h7FFFFF) ? 24'sh7FFFFF : q[23:0];
                    else r_res.out_sample <= (q > 64'h800000) ? 24'sh800000 : 24'(-q[23:0]);
                    r_st <= S_OUT;
                end
                S_OUT: if (!r_ovalid) begin
                    r_out <= r_res; r_ovalid <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
